/* sv/uart_8n1_transmitter_fifo_core_defines.svh */
// Assertion macros used by the UART transmitter engine RTL.
`ifndef UART_8N1_TRANSMITTER_FIFO_CORE_DEFINES_SVH
`define UART_8N1_TRANSMITTER_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UTX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define UTX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/uarttx_pkg.sv */
// Shared types and constants of the UART 8N1 transmitter with transmit FIFO.
`timescale 1ns / 1ps

package uarttx_pkg;

    // Transmit FIFO geometry.
    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Field widths.
    localparam int BYTE_W      = 8;
    localparam int PERIOD_W    = 16;
    localparam int ROOM_W      = 7;
    localparam int POS_W       = 4;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Small queues between the stream ports and the engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bit positions within one character frame.
    localparam logic [POS_W-1:0] START_POS     = 4'd0;
    localparam logic [POS_W-1:0] LAST_DATA_POS = 4'd8;
    localparam logic [POS_W-1:0] STOP_POS      = 4'd9;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd868;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_PERIOD = 1'b0,
        REG_TX_DISABLE = 1'b1
    } cfg_reg_t;

    // Item kinds carried in the input tuser bit.
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // Classified command handed from the front end to the engine.
    typedef struct packed {
        logic              is_tick;
        logic [BYTE_W-1:0] data_byte;
    } cmd_t;

    // One result item; tx_line sits in the lowest bit.
    typedef struct packed {
        logic              drained;
        logic              busy_res;
        logic [ROOM_W-1:0] room;
        logic              accepted;
        logic              tx_line;
    } res_t;

endpackage

/* sv/uarttx_front.sv */
// Front end: accepts input items, classifies them and queues commands.
`timescale 1ns / 1ps

module uarttx_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [uarttx_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] data_byte
    input  logic [0:0]                       s_tuser,  // [0] opcode
    output logic                             cmd_valid,
    input  logic                             cmd_ready,
    output uarttx_pkg::cmd_t                 cmd
);
    import uarttx_pkg::*;

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;
    cmd_t              in_cmd;

    // Classify the incoming item.
    assign in_cmd.is_tick   = (op_t'(s_tuser[0]) == OP_TICK);
    assign in_cmd.data_byte = s_tdata[BYTE_W-1:0];

    assign s_tready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    // Pointer and count updates.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

endmodule

/* sv/uarttx_engine.sv */
// Back end: transmit FIFO, bit timer, serializer and result queue.
`timescale 1ns / 1ps
`include "uart_8n1_transmitter_fifo_core_defines.svh"

module uarttx_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [uarttx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uarttx_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  uarttx_pkg::cmd_t                  cmd,
    output logic                              res_valid,
    input  logic                              res_ready,
    output uarttx_pkg::res_t                  res
);
    import uarttx_pkg::*;

    // Configuration registers.
    logic [PERIOD_W-1:0] bit_period_reg;
    logic                tx_disable_reg;

    // Transmit FIFO.
    logic [BYTE_W-1:0]   fifo_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0]   mem_rd_data_reg;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic                mem_we, mem_re;

    // Serializer state.
    logic                active_reg, active_next;
    logic [POS_W-1:0]    bit_pos_reg, bit_pos_next;
    logic [PERIOD_W-1:0] period_count_reg, period_count_next;
    logic                line_reg, line_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic                load_pend_reg, load_pend_next;

    // Result queue.
    res_t                oq_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   oq_wr_reg, oq_wr_next;
    logic [QPTR_W-1:0]   oq_rd_reg, oq_rd_next;
    logic [QCNT_W-1:0]   oq_cnt_reg, oq_cnt_next;
    logic                res_pop;

    logic                go;
    logic                acc;
    logic                drained;
    logic [PERIOD_W-1:0] eff_period;
    res_t                new_res;

    // An item is executed when one is queued and the result queue has space.
    assign go         = cmd_valid && (oq_cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_ready  = go;
    assign eff_period = (bit_period_reg == '0) ? PERIOD_W'(1) : bit_period_reg;

    // Item execution: FIFO push, immediate start when idle, discard while disabled, bit timer steps.
    always_comb
    begin
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        fill_next         = fill_reg;
        active_next       = active_reg;
        bit_pos_next      = bit_pos_reg;
        period_count_next = period_count_reg;
        line_next         = line_reg;
        shift_next        = load_pend_reg ? mem_rd_data_reg : shift_reg;
        load_pend_next    = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        acc               = 1'b0;
        drained           = 1'b0;
        if (go && !cmd.is_tick)
        begin
            if (tx_disable_reg)
            begin
                acc = 1'b1;
            end
            else if (!active_reg)
            begin
                // The FIFO is always empty while idle, so the byte goes
                // straight to the shifter.
                acc               = 1'b1;
                shift_next        = cmd.data_byte;
                bit_pos_next      = START_POS;
                active_next       = 1'b1;
                period_count_next = eff_period;
            end
            else if (fill_reg != CNT_W'(FIFO_DEPTH))
            begin
                acc         = 1'b1;
                mem_we      = 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
                fill_next   = fill_reg + 1'b1;
            end
        end
        else if (go && active_reg)
        begin
            if (period_count_reg > PERIOD_W'(1))
            begin
                period_count_next = period_count_reg - 1'b1;
            end
            else if (bit_pos_reg == START_POS)
            begin
                line_next         = 1'b0;
                bit_pos_next      = bit_pos_reg + 1'b1;
                period_count_next = eff_period;
            end
            else if (bit_pos_reg <= LAST_DATA_POS)
            begin
                line_next         = shift_reg[0];
                shift_next        = shift_reg >> 1;
                bit_pos_next      = bit_pos_reg + 1'b1;
                period_count_next = eff_period;
            end
            else
            begin
                // Stop bit: fetch the next byte or stop.
                line_next    = 1'b1;
                bit_pos_next = START_POS;
                if (fill_reg != '0)
                begin
                    mem_re            = 1'b1;
                    load_pend_next    = 1'b1;
                    rd_ptr_next       = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + 1'b1;
                    fill_next         = fill_reg - 1'b1;
                    period_count_next = eff_period;
                end
                else
                begin
                    active_next       = 1'b0;
                    period_count_next = '0;
                    drained           = 1'b1;
                end
            end
        end
    end

    // Result of the executed item.
    always_comb
    begin
        new_res.tx_line  = line_next;
        new_res.accepted = acc;
        new_res.room     = ROOM_W'(CNT_W'(FIFO_DEPTH) - fill_next);
        new_res.busy_res = active_next;
        new_res.drained  = drained;
    end

    // Configuration writes and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg   <= PERIOD_RESET;
            tx_disable_reg   <= 1'b0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fill_reg         <= '0;
            active_reg       <= 1'b0;
            bit_pos_reg      <= START_POS;
            period_count_reg <= '0;
            line_reg         <= 1'b1;
            load_pend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_reg_t'(cfg_index) == REG_BIT_PERIOD))
            begin
                bit_period_reg <= cfg_wdata[PERIOD_W-1:0];
            end
            if (cfg_we && (cfg_reg_t'(cfg_index) == REG_TX_DISABLE))
            begin
                tx_disable_reg <= cfg_wdata[0];
            end
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            fill_reg         <= fill_next;
            active_reg       <= active_next;
            bit_pos_reg      <= bit_pos_next;
            period_count_reg <= period_count_next;
            line_reg         <= line_next;
            load_pend_reg    <= load_pend_next;
        end
    end

    // Shifter payload.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // FIFO memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fifo_mem[wr_ptr_reg] <= cmd.data_byte;
        end
        if (mem_re)
        begin
            mem_rd_data_reg <= fifo_mem[rd_ptr_reg];
        end
    end

    // Result queue control.
    assign res_valid = (oq_cnt_reg != '0);
    assign res_pop   = res_valid && res_ready;
    assign res       = oq_reg[oq_rd_reg];

    always_comb
    begin
        oq_wr_next  = oq_wr_reg;
        oq_rd_next  = oq_rd_reg;
        oq_cnt_next = oq_cnt_reg;
        if (go)
        begin
            oq_wr_next = (oq_wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : oq_wr_reg + 1'b1;
        end
        if (res_pop)
        begin
            oq_rd_next = (oq_rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : oq_rd_reg + 1'b1;
        end
        if (go && !res_pop)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (res_pop && !go)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            oq_reg[oq_wr_reg] <= new_res;
        end
    end

    // An idle transmitter never leaves bytes behind in the FIFO.
    `UTX_ASSERT_NOW(a_idle_fifo_empty, !active_reg, fill_reg == '0, "idle with queued bytes")
    // The fill count never exceeds the FIFO depth.
    `UTX_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(FIFO_DEPTH), "fill count overflow")
    // A pending shifter load only follows a pop made while sending.
    `UTX_ASSERT_NOW(a_load_active, load_pend_reg, active_reg && bit_pos_reg == START_POS,
        "shifter load outside start bit")
    // A drained pulse leaves the transmitter stopped and the line high.
    `UTX_ASSERT_NEXT(a_drain_stop, go && drained, !active_reg && line_reg,
        "drained without stopping")

endmodule

/* sv/uart_8n1_transmitter_fifo_core.sv */
// Top level of the UART 8N1 transmitter with a 64-byte transmit FIFO.
//
//  Port group     Dir   Payload                                   Handshake
//  s_*            in    tuser[0] opcode, tdata[7:0] data_byte    s_tvalid/s_tready
//  m_*            out   tdata: tx_line, accepted, room, busy,     m_tvalid/m_tready
//                       drained (see port comment)
//  cfg_*          in    index 0 bit_period, index 1 tx_disable   cfg_we, no wait
//
// One item is accepted per clock cycle while the input queue has room, write or tick
// alike; it waits in the input queue, and its result in the result queue.
// Each side has a two-entry queue, so either side may stall on its own.
// The FIFO is a single-port-write, registered-read memory; a popped byte
// passes through the read register into the shifter before its first data bit is due.
// Reset is asynchronous and active low; the FIFO memory needs no clearing pass.
`timescale 1ns / 1ps

module uart_8n1_transmitter_fifo_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [uarttx_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]                         s_tuser,   // [0] opcode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] tx_line, [1] accepted, [8:2] room, [9] busy_res, [10] drained,
    // [15:11] zero
    output logic [uarttx_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                               cfg_we,
    input  logic [uarttx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uarttx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import uarttx_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;
    res_t res;

    // Input acceptance and command queue.
    uarttx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Transmit engine and result queue.
    uarttx_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result item, zero filled to whole bytes.
    assign m_tdata = {(OUT_TDATA_W - $bits(res_t))'(0), res};

endmodule
